// ----- hdl/ydvr_pkg.sv -----
`timescale 1ns / 1ps

package ydvr_pkg;

  // Default parameter values for the top level.
  localparam int DEF_CORDIC_STAGES = 16;
  localparam int DEF_MOVE_WIDTH    = 16;

  // Length of the arctangent table; more stages than this are not built.
  localparam int TABLE_LEN = 24;

  // Heading and angle formats (degrees times 128).
  localparam int HEAD_W = 17;
  localparam int DIFF_W = 18;
  localparam int ANG_W  = 16;

  localparam logic signed [DIFF_W-1:0] FULL_TURN    = 18'sd46080;
  localparam logic signed [DIFF_W-1:0] TWO_TURNS    = 18'sd92160;
  localparam logic signed [DIFF_W-1:0] HALF_TURN    = 18'sd23040;
  localparam logic signed [DIFF_W-1:0] QUARTER_TURN = 18'sd11520;

  // Angle accumulator in degrees times 2^20.
  localparam int ZW             = 30;
  localparam int ANGLE_UP_SHIFT = 13;

  // Guard bits carried below the movement value in the vector lanes.
  localparam int GUARD_BITS = 16;

  // CORDIC gain correction, round(0.60725293500888 * 2^30).
  localparam int          GAIN_W   = 30;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

  // Split point of the lane magnitude for the two partial products.
  localparam int SPLIT_W = 24;

  // Rounding bias added before the final right shift by 22.
  localparam int ROUND_SHIFT = 22;

  // Arctangent of 2^-i in degrees times 2^20, rounded.
  function automatic logic signed [ZW-1:0] atan_deg20(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = 30'sd47185920;
      1:       v = 30'sd27855475;
      2:       v = 30'sd14718068;
      3:       v = 30'sd7471121;
      4:       v = 30'sd3750058;
      5:       v = 30'sd1876857;
      6:       v = 30'sd938658;
      7:       v = 30'sd469357;
      8:       v = 30'sd234682;
      9:       v = 30'sd117342;
      10:      v = 30'sd58671;
      11:      v = 30'sd29335;
      12:      v = 30'sd14668;
      13:      v = 30'sd7334;
      14:      v = 30'sd3667;
      15:      v = 30'sd1833;
      16:      v = 30'sd917;
      17:      v = 30'sd458;
      18:      v = 30'sd229;
      19:      v = 30'sd115;
      20:      v = 30'sd57;
      21:      v = 30'sd29;
      22:      v = 30'sd14;
      23:      v = 30'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/ydvr_prep.sv -----
`timescale 1ns / 1ps

module ydvr_prep #(
  parameter int MW = 16
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [ydvr_pkg::HEAD_W-1:0]  old_heading,
  input  logic signed [ydvr_pkg::HEAD_W-1:0]  new_heading,
  input  logic signed [MW-1:0]                fwd_in,
  input  logic signed [MW-1:0]                side_in,
  output logic signed [ydvr_pkg::ANG_W-1:0]   angle,
  output logic                                flip,
  output logic signed [MW-1:0]                fwd_out,
  output logic signed [MW-1:0]                side_out
);
  import ydvr_pkg::*;

  logic signed [DIFF_W-1:0] old_ext, new_ext, old_fold, new_fold;
  logic signed [DIFF_W-1:0] diff_nxt, diff_r;
  logic signed [DIFF_W-1:0] d_nxt, d_r;
  logic signed [DIFF_W-1:0] a_full;
  logic signed [ANG_W-1:0]  angle_nxt, angle_r;
  logic                     flip_nxt, flip_r;
  logic signed [MW-1:0]     fwd1_r, side1_r, fwd2_r, side2_r, fwd3_r, side3_r;

  // First step: add a full turn to each negative heading and take the difference.
  always_comb begin
    old_ext  = DIFF_W'(old_heading);
    new_ext  = DIFF_W'(new_heading);
    old_fold = (old_ext < 0) ? old_ext + FULL_TURN : old_ext;
    new_fold = (new_ext < 0) ? new_ext + FULL_TURN : new_ext;
    diff_nxt = new_fold - old_fold;
  end

  // Second step: reduce the difference modulo a full turn into 0..360.
  always_comb begin
    if (diff_r >= FULL_TURN) begin
      d_nxt = diff_r - FULL_TURN;
    end else if (diff_r >= 0) begin
      d_nxt = diff_r;
    end else if (diff_r >= -FULL_TURN) begin
      d_nxt = diff_r + FULL_TURN;
    end else begin
      d_nxt = diff_r + TWO_TURNS;
    end
  end

  // Third step: bring the angle into -90..90, flipping the result when
  // a half turn was taken off.
  always_comb begin
    flip_nxt = 1'b0;
    if (d_r <= QUARTER_TURN) begin
      a_full = d_r;
    end else if (d_r < FULL_TURN - QUARTER_TURN) begin
      a_full   = d_r - HALF_TURN;
      flip_nxt = 1'b1;
    end else begin
      a_full = d_r - FULL_TURN;
    end
    angle_nxt = ANG_W'(a_full);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r  <= diff_nxt;
      d_r     <= d_nxt;
      angle_r <= angle_nxt;
      flip_r  <= flip_nxt;
      fwd1_r  <= fwd_in;
      side1_r <= side_in;
      fwd2_r  <= fwd1_r;
      side2_r <= side1_r;
      fwd3_r  <= fwd2_r;
      side3_r <= side2_r;
    end
  end

  assign angle    = angle_r;
  assign flip     = flip_r;
  assign fwd_out  = fwd3_r;
  assign side_out = side3_r;

endmodule

// ----- hdl/ydvr_cell.sv -----
`timescale 1ns / 1ps

module ydvr_cell #(
  parameter int LW    = 34,
  parameter int SHIFT = 0
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [LW-1:0]            x_in,
  input  logic signed [LW-1:0]            y_in,
  input  logic signed [ydvr_pkg::ZW-1:0]  z_in,
  input  logic                            flip_in,
  output logic signed [LW-1:0]            x_out,
  output logic signed [LW-1:0]            y_out,
  output logic signed [ydvr_pkg::ZW-1:0]  z_out,
  output logic                            flip_out
);
  import ydvr_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = atan_deg20(SHIFT);

  logic signed [LW-1:0] xs, ys, x_nxt, y_nxt, x_r, y_r;
  logic signed [ZW-1:0] z_nxt, z_r;
  logic                 flip_r;

  // One micro-rotation: turn toward zero residual angle.
  always_comb begin
    xs = x_in >>> SHIFT;
    ys = y_in >>> SHIFT;
    if (z_in >= 0) begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ATAN;
    end else begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      flip_r <= flip_in;
    end
  end

  assign x_out    = x_r;
  assign y_out    = y_r;
  assign z_out    = z_r;
  assign flip_out = flip_r;

endmodule

// ----- hdl/ydvr_gain.sv -----
`timescale 1ns / 1ps

module ydvr_gain #(
  parameter int LW = 34,
  parameter int MW = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [LW-1:0]  lane,
  input  logic                  flip,
  output logic signed [MW-1:0]  result
);
  import ydvr_pkg::*;

  localparam int HW  = LW - SPLIT_W;
  localparam int PHW = HW + GAIN_W;
  localparam int PLW = SPLIT_W + GAIN_W;
  localparam int SW  = PHW + 1;
  localparam int RW  = SW - ROUND_SHIFT;
  localparam int VW  = RW + 1;
  localparam logic signed [VW-1:0] MAX_V = VW'((64'sd1 <<< (MW - 1)) - 64'sd1);
  localparam logic signed [VW-1:0] MIN_V = -MAX_V - VW'(1);
  localparam logic [SW-1:0] BIAS = SW'(1) << (ROUND_SHIFT - 1);

  logic          neg0_r, neg1_r, neg2_r;
  logic [LW-1:0] mag_nxt, mag_r;
  logic [PHW-1:0] p_hi_nxt, p_hi_r;
  logic [PLW-1:0] p_lo_nxt, p_lo_r;
  logic [SW-1:0]  sum;
  logic [RW-1:0]  r_nxt, r_r;
  logic signed [VW-1:0] v;
  logic signed [MW-1:0] res_nxt, res_r;

  // Sign and magnitude; the half-turn flip folds into the sign.
  assign mag_nxt = lane[LW-1] ? LW'(-lane) : LW'(lane);

  // Two partial products of the magnitude with the gain constant.
  always_comb begin
    p_lo_nxt = PLW'(mag_r[SPLIT_W-1:0]) * PLW'(GAIN_Q30);
    p_hi_nxt = PHW'(mag_r[LW-1:SPLIT_W]) * PHW'(GAIN_Q30);
  end

  // Recombine, round half up and drop the guard bits.
  always_comb begin
    sum   = SW'(p_hi_r) + BIAS + SW'(p_lo_r[PLW-1:SPLIT_W]);
    r_nxt = sum[SW-1:ROUND_SHIFT];
  end

  // Restore the sign and saturate to the output width.
  always_comb begin
    v = neg2_r ? -signed'({1'b0, r_r}) : signed'({1'b0, r_r});
    if (v > MAX_V) begin
      res_nxt = MW'(MAX_V);
    end else if (v < MIN_V) begin
      res_nxt = MW'(MIN_V);
    end else begin
      res_nxt = MW'(v);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg0_r <= lane[LW-1] ^ flip;
      mag_r  <= mag_nxt;
      neg1_r <= neg0_r;
      p_lo_r <= p_lo_nxt;
      p_hi_r <= p_hi_nxt;
      neg2_r <= neg1_r;
      r_r    <= r_nxt;
      res_r  <= res_nxt;
    end
  end

  assign result = res_r;

endmodule

// ----- hdl/yaw_delta_vector_rotator.sv -----
`timescale 1ns / 1ps
// Channel   Ports                                               Direction
// input     in_valid, in_stall, in_old_heading, in_new_heading,  in
//           in_forward_in, in_side_in
// result    out_valid, out_stall, out_forward_out, out_side_out  out
//
// One item is accepted every cycle while the pipeline is not stalled; it passes through
// three angle-reduction stages, one per CORDIC cell (CORDIC_STAGES, capped at TABLE_LEN)
// and four gain-correction stages, the first loaded at the accepting edge.
// Reset (rst_n low, synchronous) clears the valid bits of every stage.
// A stalled result freezes the whole pipeline; in_stall is high exactly
// while a result waits and out_stall is high.

module yaw_delta_vector_rotator #(
  parameter int CORDIC_STAGES = ydvr_pkg::DEF_CORDIC_STAGES,
  parameter int MOVE_WIDTH    = ydvr_pkg::DEF_MOVE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ydvr_pkg::HEAD_W-1:0]  in_old_heading,
  input  logic signed [ydvr_pkg::HEAD_W-1:0]  in_new_heading,
  input  logic signed [MOVE_WIDTH-1:0]        in_forward_in,
  input  logic signed [MOVE_WIDTH-1:0]        in_side_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [MOVE_WIDTH-1:0]        out_forward_out,
  output logic signed [MOVE_WIDTH-1:0]        out_side_out
);
  import ydvr_pkg::*;

  localparam int NS = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int LW = MOVE_WIDTH + GUARD_BITS + 2;
  localparam int PREP_STAGES = 3;
  localparam int GAIN_STAGES = 4;
  localparam int L  = PREP_STAGES + NS + GAIN_STAGES;

  logic         adv;
  logic [L-1:0] vld_r, vld_nxt;

  logic signed [ANG_W-1:0]      angle;
  logic                         flip_p;
  logic signed [MOVE_WIDTH-1:0] fwd_p, side_p;

  logic signed [LW-1:0] x_s [0:NS];
  logic signed [LW-1:0] y_s [0:NS];
  logic signed [ZW-1:0] z_s [0:NS];
  logic                 f_s [0:NS];

  // The pipeline moves whenever the output register is free or being taken.
  assign adv      = !vld_r[L-1] || !out_stall;
  assign in_stall = !adv;

  // Stage valid bits.
  always_comb begin
    vld_nxt = {vld_r[L-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // Heading difference and quadrant reduction.
  ydvr_prep #(.MW(MOVE_WIDTH)) u_prep (
    .clk         (clk),
    .en          (adv),
    .old_heading (in_old_heading),
    .new_heading (in_new_heading),
    .fwd_in      (in_forward_in),
    .side_in     (in_side_in),
    .angle       (angle),
    .flip        (flip_p),
    .fwd_out     (fwd_p),
    .side_out    (side_p)
  );

  // Lanes enter the cell chain with the guard bits appended.
  assign x_s[0] = LW'(fwd_p) <<< GUARD_BITS;
  assign y_s[0] = LW'(side_p) <<< GUARD_BITS;
  assign z_s[0] = ZW'(angle) <<< ANGLE_UP_SHIFT;
  assign f_s[0] = flip_p;

  // Chain of CORDIC cells, one micro-rotation each.
  for (genvar i = 0; i < NS; i++) begin : g_cell
    ydvr_cell #(.LW(LW), .SHIFT(i)) u_cell (
      .clk      (clk),
      .en       (adv),
      .x_in     (x_s[i]),
      .y_in     (y_s[i]),
      .z_in     (z_s[i]),
      .flip_in  (f_s[i]),
      .x_out    (x_s[i+1]),
      .y_out    (y_s[i+1]),
      .z_out    (z_s[i+1]),
      .flip_out (f_s[i+1])
    );
  end

  // Gain correction, rounding and saturation for each lane.
  ydvr_gain #(.LW(LW), .MW(MOVE_WIDTH)) u_gain_fwd (
    .clk    (clk),
    .en     (adv),
    .lane   (x_s[NS]),
    .flip   (f_s[NS]),
    .result (out_forward_out)
  );

  ydvr_gain #(.LW(LW), .MW(MOVE_WIDTH)) u_gain_side (
    .clk    (clk),
    .en     (adv),
    .lane   (y_s[NS]),
    .flip   (f_s[NS]),
    .result (out_side_out)
  );

  assign out_valid = vld_r[L-1];

  // The input side stalls only while a result is held at the output.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // A reduced angle entering the cell chain lies within a quarter turn.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[PREP_STAGES-1] |-> (angle >= -ANG_W'(QUARTER_TURN) && angle <= ANG_W'(QUARTER_TURN)))
    else $error("reduced angle out of range");

  // A new result only appears after the pipeline advanced.
  a_result_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(adv))
    else $error("result appeared while the pipeline was held");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int HEADING_W = ydvr_pkg::HEAD_W;
  localparam int MOVE_W    = ydvr_pkg::DEF_MOVE_WIDTH;
  localparam int STAGES    = ydvr_pkg::DEF_CORDIC_STAGES;
  localparam int ATAN_LEN  = 24;
  localparam int LATENCY   = ((STAGES > ATAN_LEN) ? ATAN_LEN : STAGES) + 7;

  // Angles in degrees times 128.
  localparam longint TURN_DEG128    = 46080;
  localparam longint HALF_DEG128    = 23040;
  localparam longint QUARTER_DEG128 = 11520;
  localparam longint MOVE_MAX       = (longint'(1) <<< (MOVE_W - 1)) - 1;
  localparam longint MOVE_MIN       = -MOVE_MAX - 1;
  localparam longint GAIN_COMP_Q30  = 652032874;

  typedef struct packed {
    logic signed [HEADING_W-1:0] old_heading;
    logic signed [HEADING_W-1:0] new_heading;
    logic signed [MOVE_W-1:0]    forward;
    logic signed [MOVE_W-1:0]    side;
  } move_cmd_t;

  typedef struct packed {
    logic signed [MOVE_W-1:0] forward;
    logic signed [MOVE_W-1:0] side;
  } move_vec_t;

  typedef enum {PH_STEADY, PH_SENDER_IDLE, PH_RECEIVER_STALL, PH_BOTH_IDLE} idle_phase_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [HEADING_W-1:0] in_old_heading = '0;
  logic signed [HEADING_W-1:0] in_new_heading = '0;
  logic signed [MOVE_W-1:0]    in_forward_in = '0;
  logic signed [MOVE_W-1:0]    in_side_in = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [MOVE_W-1:0]    out_forward_out;
  logic signed [MOVE_W-1:0]    out_side_out;

  // Arctangent of 2^-i in degrees times 2^20.
  longint arctan_deg20 [0:ATAN_LEN-1] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  move_cmd_t pending_cmds[$];
  move_vec_t expected_vectors[$];
  move_cmd_t next_cmd;
  int        accepted_count = 0;
  int        error_count = 0;
  int        hold_left = 0;
  bit        pressure_done = 1'b0;

  yaw_delta_vector_rotator #(
    .CORDIC_STAGES(STAGES),
    .MOVE_WIDTH(MOVE_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_old_heading(in_old_heading),
    .in_new_heading(in_new_heading),
    .in_forward_in(in_forward_in),
    .in_side_in(in_side_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_forward_out(out_forward_out),
    .out_side_out(out_side_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Removes the CORDIC gain: magnitude times K, rounded half away from zero,
  // guard bits dropped.
  function automatic longint remove_gain(longint v);
    bit [63:0] mag;
    bit [63:0] hi;
    bit [63:0] lo;
    bit [63:0] scaled;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    hi = mag >> 24;
    lo = mag & 64'hFF_FFFF;
    scaled = (hi * 64'(GAIN_COMP_Q30) + (64'd1 << 21) + ((lo * 64'(GAIN_COMP_Q30)) >> 24)) >> 22;
    return (v < 0) ? -longint'(scaled) : longint'(scaled);
  endfunction

  function automatic logic signed [MOVE_W-1:0] clamp_move(longint v);
    if (v > MOVE_MAX) return MOVE_W'(MOVE_MAX);
    if (v < MOVE_MIN) return MOVE_W'(MOVE_MIN);
    return MOVE_W'(v);
  endfunction

  // Rotates (forward, side) by the heading change new minus old, mod 360.
  function automatic move_vec_t rotate_by_yaw_change(move_cmd_t c);
    longint old_h;
    longint new_h;
    longint delta;
    longint angle;
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    bit flip;
    int n_stages;
    int i;
    move_vec_t r;
    old_h = c.old_heading;
    new_h = c.new_heading;
    if (old_h < 0) old_h += TURN_DEG128;
    if (new_h < 0) new_h += TURN_DEG128;
    delta = (new_h - old_h) % TURN_DEG128;
    if (delta < 0) delta += TURN_DEG128;

    // Fold the angle into -90..90; the back half turns by 180 and negates.
    flip = 1'b0;
    if (delta <= QUARTER_DEG128) begin
      angle = delta;
    end else if (delta < TURN_DEG128 - QUARTER_DEG128) begin
      angle = delta - HALF_DEG128;
      flip = 1'b1;
    end else begin
      angle = delta - TURN_DEG128;
    end

    z = angle * 8192;
    x = longint'(c.forward) * 65536;
    y = longint'(c.side) * 65536;
    n_stages = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;
    for (i = 0; i < n_stages; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_deg20[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_deg20[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    r.forward = clamp_move(remove_gain(x));
    r.side = clamp_move(remove_gain(y));
    return r;
  endfunction

  function automatic move_cmd_t make_cmd(int old_h, int new_h, int fwd, int side);
    move_cmd_t c;
    c.old_heading = HEADING_W'(old_h);
    c.new_heading = HEADING_W'(new_h);
    c.forward = MOVE_W'(fwd);
    c.side = MOVE_W'(side);
    return c;
  endfunction

  // Mostly legal headings, some near quarter-turn boundaries, some raw patterns.
  function automatic int random_heading();
    case ($urandom_range(0, 7))
      0: return int'($urandom_range(0, 131071)) - 65536;
      1: return (int'($urandom_range(0, 7)) - 4) * 11520 + int'($urandom_range(0, 2)) - 1;
      default: return int'($urandom_range(0, 92159)) - 46080;
    endcase
  endfunction

  function automatic int random_move();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return int'($urandom_range(0, 127)) - 64;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Idle rate for the sender or the receiver, by how far the run has come.
  function automatic bit draw_idle(bit for_receiver);
    idle_phase_t ph;
    if (accepted_count < 150) ph = PH_STEADY;
    else if (accepted_count < 350) ph = PH_SENDER_IDLE;
    else if (accepted_count < 550) ph = PH_RECEIVER_STALL;
    else if (accepted_count < 700) ph = PH_BOTH_IDLE;
    else ph = PH_STEADY;
    case (ph)
      PH_SENDER_IDLE: return !for_receiver && ($urandom_range(0, 99) < 76);
      PH_RECEIVER_STALL: return for_receiver && ($urandom_range(0, 99) < 76);
      PH_BOTH_IDLE: return $urandom_range(0, 99) < 25;
      default: return 1'b0;
    endcase
  endfunction

  // Driver: records each accepted item's rotation and offers the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_vectors.push_back(rotate_by_yaw_change(
          {in_old_heading, in_new_heading, in_forward_in, in_side_in}));
        accepted_count <= accepted_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() != 0 && !draw_idle(1'b0)) begin
          next_cmd = pending_cmds.pop_front();
          in_old_heading <= next_cmd.old_heading;
          in_new_heading <= next_cmd.new_heading;
          in_forward_in <= next_cmd.forward;
          in_side_in <= next_cmd.side;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result item and drives the receiver's stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_vectors.size() == 0) begin
          $error("unexpected result item: forward_out %0d, side_out %0d",
                 out_forward_out, out_side_out);
          error_count++;
        end else begin
          if (out_forward_out !== expected_vectors[0].forward) begin
            $error("forward_out mismatch: expected %0d, actual %0d",
                   expected_vectors[0].forward, out_forward_out);
            error_count++;
          end
          if (out_side_out !== expected_vectors[0].side) begin
            $error("side_out mismatch: expected %0d, actual %0d",
                   expected_vectors[0].side, out_side_out);
            error_count++;
          end
          void'(expected_vectors.pop_front());
        end
      end
      // One long hold-off early on fills the pipeline and backs up the input.
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!pressure_done && accepted_count >= 40) begin
        pressure_done <= 1'b1;
        hold_left <= 120;
        out_stall <= 1'b1;
      end else begin
        out_stall <= draw_idle(1'b1);
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    // Zero angle, exact and just-past quarter turns, half turn, saturation.
    pending_cmds.push_back(make_cmd(0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(0, 0, 32767, -32768));
    pending_cmds.push_back(make_cmd(0, 11520, 32767, 0));
    pending_cmds.push_back(make_cmd(0, 11521, 1000, -1000));
    pending_cmds.push_back(make_cmd(0, 23040, -32768, -32768));
    pending_cmds.push_back(make_cmd(0, 34560, 12345, -4321));
    pending_cmds.push_back(make_cmd(0, 34559, 32767, 32767));
    pending_cmds.push_back(make_cmd(46079, -46080, 100, 200));
    pending_cmds.push_back(make_cmd(-46080, 46079, -32768, 32767));
    pending_cmds.push_back(make_cmd(-1, 0, 32767, 32767));
    pending_cmds.push_back(make_cmd(0, 5760, 32767, 32767));
    pending_cmds.push_back(make_cmd(5760, 0, 32767, -32768));
    // Headings outside +-360, down to the extremes of the 17-bit field.
    pending_cmds.push_back(make_cmd(-65536, 65535, 32767, -32768));
    pending_cmds.push_back(make_cmd(65535, -65536, -32768, 32767));
    pending_cmds.push_back(make_cmd(23040, -23040, 1, -1));
    pending_cmds.push_back(make_cmd(-11520, 11520, -32768, 0));
    pending_cmds.push_back(make_cmd(0, -1, 16, 16));
    pending_cmds.push_back(make_cmd(11520, 0, -1, 32767));
    repeat (800) begin
      pending_cmds.push_back(make_cmd(random_heading(), random_heading(),
                                      random_move(), random_move()));
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (expected_vectors.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    if (error_count == 0 && expected_vectors.size() == 0) begin
      $display("yaw_delta_vector_rotator test passed");
    end else begin
      $display("yaw_delta_vector_rotator test failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("yaw_delta_vector_rotator test failed");
    $finish;
  end

endmodule
